### rtl/hsvrgb_pkg.sv
// Shared types and constants for the HSV to packed RGB converter.
`default_nettype none
package hsvrgb_pkg;

  localparam int unsigned HueW = 17;
  localparam int unsigned ChanW = 8;
  localparam int unsigned PixW = 32;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned BitsW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 5;

  // one 60 degree sector in 1/256 degree steps
  localparam int unsigned SectorSpan = 60 * 256;
  localparam int unsigned FracW = 14;
  localparam int unsigned SdW = 22;
  // 256 * SectorSpan = 15 * 2**18
  localparam int unsigned RampFull = 256 * SectorSpan;
  localparam int unsigned RampShift = 18;
  localparam int unsigned QuotW = 12;
  // ceil(2**16 / 15), exact for quotients below 4681
  localparam int unsigned Recip15 = 4370;
  localparam int unsigned Recip15W = 13;

  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_RED_SHIFT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RED_BITS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GREEN_SHIFT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GREEN_BITS  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BLUE_SHIFT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BLUE_BITS   = 3'd5;

  typedef struct packed {
    logic [ShiftW-1:0] shift;
    logic [BitsW-1:0]  bits;
  } chan_cfg_t;

endpackage
`default_nettype wire

### rtl/hsvrgb_pack_lane.sv
// One channel of the pixel packer: mask to the kept length, shift into place.
`default_nettype none
module hsvrgb_pack_lane (
  input  logic [7:0]              level_i,
  input  hsvrgb_pkg::chan_cfg_t   cfg_i,
  output logic [31:0]             word_o
);
  import hsvrgb_pkg::*;

  logic [BitsW-1:0] keep;
  logic [ChanW-1:0] mask;

  always_comb begin
    keep = (cfg_i.bits > BitsW'(ChanW)) ? BitsW'(ChanW) : cfg_i.bits;
    mask = ~({ChanW{1'b1}} << keep);
    word_o = PixW'(level_i & mask) << cfg_i.shift;
  end

endmodule
`default_nettype wire

### rtl/hsv_to_packed_rgb_unit.sv
// HSV to RGB converter with configurable packed pixel output, 5-stage pipeline.
//
//  channel   dir  beat contents (low bit first)
//  s_axis    in   tdata: hue[16:0], saturation[24:17], brightness[32:25], pad to 40
//  m_axis    out  tdata: pixel_word[31:0], red[39:32], green[47:40], blue[55:48]
//  cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, one register per write
//
// Five register stages: sector split, two products, ramp product, channel
// select, pack. One beat per cycle sustained while the output is empty or taken.
// The whole pipe advances together when the output register is empty or taken;
// s_axis_tready follows that condition.
// Reset clears valid bits and loads the default 8:8:8 layout at 16/8/0.
`default_nettype none
module hsv_to_packed_rgb_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [39:0]                       s_axis_tdata,  // hue, saturation, brightness
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [55:0]                       m_axis_tdata,  // pixel_word, red, green, blue
  input  logic                              cfg_we_i,
  input  logic [hsvrgb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hsvrgb_pkg::CfgDataW-1:0]   cfg_data_i
);
  import hsvrgb_pkg::*;

  logic adv;

  // configuration
  chan_cfg_t red_cfg_q, grn_cfg_q, blu_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cfg_q <= '{shift: ShiftW'(16), bits: BitsW'(8)};
      grn_cfg_q <= '{shift: ShiftW'(8), bits: BitsW'(8)};
      blu_cfg_q <= '{shift: ShiftW'(0), bits: BitsW'(8)};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RED_SHIFT:   red_cfg_q.shift <= cfg_data_i;
        REG_RED_BITS:    red_cfg_q.bits  <= cfg_data_i[BitsW-1:0];
        REG_GREEN_SHIFT: grn_cfg_q.shift <= cfg_data_i;
        REG_GREEN_BITS:  grn_cfg_q.bits  <= cfg_data_i[BitsW-1:0];
        REG_BLUE_SHIFT:  blu_cfg_q.shift <= cfg_data_i;
        REG_BLUE_BITS:   blu_cfg_q.bits  <= cfg_data_i[BitsW-1:0];
        default: ;
      endcase
    end
  end

  // valid bits
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;

  assign adv           = !vld5_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (adv) begin
      vld1_q <= s_axis_tvalid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  // stage 1: sector and ramp distance
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] sat_in, bri_in;
  logic [2:0]       sec_d;
  logic             blk_d;
  logic [HueW-1:0]  base;
  logic [FracW-1:0] frac, dist_d;

  assign hue    = s_axis_tdata[16:0];
  assign sat_in = s_axis_tdata[24:17];
  assign bri_in = s_axis_tdata[32:25];

  always_comb begin
    blk_d = 1'b0;
    sec_d = SEC_RY;
    base  = '0;
    priority if (hue >= HueW'(6 * SectorSpan)) begin
      blk_d = 1'b1;
    end else if (hue >= HueW'(5 * SectorSpan)) begin
      sec_d = SEC_MR;
      base  = HueW'(5 * SectorSpan);
    end else if (hue >= HueW'(4 * SectorSpan)) begin
      sec_d = SEC_BM;
      base  = HueW'(4 * SectorSpan);
    end else if (hue >= HueW'(3 * SectorSpan)) begin
      sec_d = SEC_CB;
      base  = HueW'(3 * SectorSpan);
    end else if (hue >= HueW'(2 * SectorSpan)) begin
      sec_d = SEC_GC;
      base  = HueW'(2 * SectorSpan);
    end else if (hue >= HueW'(SectorSpan)) begin
      sec_d = SEC_YG;
      base  = HueW'(SectorSpan);
    end else begin
      sec_d = SEC_RY;
      base  = '0;
    end
    frac   = FracW'(hue - base);
    dist_d = sec_d[0] ? frac : FracW'(FracW'(SectorSpan) - frac);
  end

  logic [2:0]       sec1_q, sec2_q, sec3_q;
  logic             blk1_q, blk2_q, blk3_q, blk4_q;
  logic [FracW-1:0] dist1_q;
  logic [ChanW-1:0] sat1_q, bri1_q, bri2_q, bri3_q, p2_q, p3_q;
  logic [SdW-1:0]   sd2_q;
  logic [QuotW-1:0] q3_q;

  // stage 2: s*d and low channel
  logic [SdW-1:0]    sd_d;
  logic [16:0]       plow;
  // stage 3: ramp product
  logic [SdW-1:0]    ramp_t;
  logic [29:0]       ramp_prod;
  // stage 4: divide by 15 and channel select
  logic [23:0]       div_prod;
  logic [ChanW-1:0]  x_lvl;
  logic [ChanW-1:0]  r_d, g_d, b_d;
  logic [ChanW-1:0]  r4_q, g4_q, b4_q;

  always_comb begin
    sd_d      = SdW'(sat1_q) * SdW'(dist1_q);
    plow      = 17'(bri1_q) * 17'(9'd256 - 9'(sat1_q));
    ramp_t    = SdW'(RampFull) - sd2_q;
    ramp_prod = 30'(bri2_q) * 30'(ramp_t);
    div_prod  = 24'(q3_q) * 24'(Recip15W'(Recip15));
    x_lvl     = div_prod[23:16];
  end

  always_comb begin
    r_d = '0;
    g_d = '0;
    b_d = '0;
    unique case (sec3_q)
      SEC_RY: begin r_d = bri3_q; g_d = x_lvl;  b_d = p3_q;   end
      SEC_YG: begin r_d = x_lvl;  g_d = bri3_q; b_d = p3_q;   end
      SEC_GC: begin r_d = p3_q;   g_d = bri3_q; b_d = x_lvl;  end
      SEC_CB: begin r_d = p3_q;   g_d = x_lvl;  b_d = bri3_q; end
      SEC_BM: begin r_d = x_lvl;  g_d = p3_q;   b_d = bri3_q; end
      SEC_MR: begin r_d = bri3_q; g_d = p3_q;   b_d = x_lvl;  end
      default: ;
    endcase
    if (blk3_q) begin
      r_d = '0;
      g_d = '0;
      b_d = '0;
    end
  end

  // stage 5: pack
  logic [PixW-1:0] r_word, g_word, b_word;
  logic [PixW-1:0] pix5_q;
  logic [ChanW-1:0] r5_q, g5_q, b5_q;

  hsvrgb_pack_lane u_lane_r (.level_i(r4_q), .cfg_i(red_cfg_q), .word_o(r_word));
  hsvrgb_pack_lane u_lane_g (.level_i(g4_q), .cfg_i(grn_cfg_q), .word_o(g_word));
  hsvrgb_pack_lane u_lane_b (.level_i(b4_q), .cfg_i(blu_cfg_q), .word_o(b_word));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec1_q  <= sec_d;
      blk1_q  <= blk_d;
      dist1_q <= dist_d;
      sat1_q  <= sat_in;
      bri1_q  <= bri_in;

      sec2_q  <= sec1_q;
      blk2_q  <= blk1_q;
      bri2_q  <= bri1_q;
      sd2_q   <= sd_d;
      p2_q    <= plow[15:8];

      sec3_q  <= sec2_q;
      blk3_q  <= blk2_q;
      bri3_q  <= bri2_q;
      p3_q    <= p2_q;
      q3_q    <= ramp_prod[RampShift +: QuotW];

      blk4_q  <= blk3_q;
      r4_q    <= r_d;
      g4_q    <= g_d;
      b4_q    <= b_d;

      pix5_q  <= r_word | g_word | b_word;
      r5_q    <= r4_q;
      g5_q    <= g4_q;
      b5_q    <= b4_q;
    end
  end

  assign m_axis_tdata = {b5_q, g5_q, r5_q, pix5_q};

`ifndef NO_ASSERTIONS
  a_low_le_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> (p3_q <= bri3_q))
    else $error("low channel exceeds value");

  a_black_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld4_q && blk4_q) |=> (r5_q == '0 && g5_q == '0 && b5_q == '0))
    else $error("out-of-range hue gave nonzero channels");

  a_peak_is_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld3_q && !blk3_q) |=>
      (r4_q == $past(bri3_q) || g4_q == $past(bri3_q) || b4_q == $past(bri3_q)))
    else $error("no channel carries the value level");

  a_zero_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld5_q && r5_q == '0 && g5_q == '0 && b5_q == '0) |-> (pix5_q == '0))
    else $error("black pixel packed nonzero");
`endif

endmodule
`default_nettype wire
